// ===== sv/ir_remote_command_receiver_top_macros.svh =====
// Assertion macros shared by the IR remote command receiver modules.
`ifndef IR_REMOTE_COMMAND_RECEIVER_TOP_MACROS_SVH
`define IR_REMOTE_COMMAND_RECEIVER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IRRX_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define IRRX_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

// ===== sv/irrx_pkg.sv =====
// Shared types and constants for the IR remote command receiver.
`timescale 1ns / 1ps
package irrx_pkg;

	localparam int DATA_BITS      = 8;
	localparam int STOP_PERIODS   = 3;
	localparam int LAST_BIT_INDEX = DATA_BITS + STOP_PERIODS - 1;
	localparam int BIT_INDEX_W    = 4;

	localparam int CMD_DEPTH = 4;
	localparam int OUT_DEPTH = 2;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [15:0] BIT_PERIOD_RESET  = 16'd100;
	localparam logic [15:0] BIT_PERIOD_MIN    = 16'd2;
	localparam logic [7:0]  VOLUME_MAX_RESET  = 8'd10;
	localparam logic [7:0]  CHANNEL_MAX_RESET = 8'd20;
	localparam logic [7:0]  VOLUME_RESET      = 8'd0;
	localparam logic [7:0]  CHANNEL_MIN       = 8'd1;

	// Register indexes, taken from paddr[3:2].
	localparam logic [1:0] REG_BIT_PERIOD  = 2'd0;
	localparam logic [1:0] REG_VOLUME_MAX  = 2'd1;
	localparam logic [1:0] REG_CHANNEL_MAX = 2'd2;

	// Command codes.
	localparam logic [7:0] CMD_VOL_UP   = 8'd1;
	localparam logic [7:0] CMD_VOL_DOWN = 8'd2;
	localparam logic [7:0] CMD_MUTE     = 8'd3;
	localparam logic [7:0] CMD_CH_UP    = 8'd4;
	localparam logic [7:0] CMD_CH_DOWN  = 8'd5;
	localparam logic [7:0] CMD_CH_RESET = 8'd6;

	localparam logic [1:0] IND_SILENT = 2'd0;
	localparam logic [1:0] IND_DONE   = 2'd1;
	localparam logic [1:0] IND_DOUBLE = 2'd2;

	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_CONFIRM = 2'd1,
		PH_DATA    = 2'd2
	} rx_phase_t;

	typedef struct packed {
		logic [7:0] command_code;
		logic [7:0] volume_level;
		logic [7:0] channel_number;
		logic [1:0] indication;
	} result_t;

endpackage

// ===== sv/irrx_fifo.sv =====
// Small first-word-fall-through queue built from registers.
`timescale 1ns / 1ps
module irrx_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/irrx_front.sv =====
// Line sampler: finds the start bit, samples the data bits and emits the received byte.
`timescale 1ns / 1ps
`include "ir_remote_command_receiver_top_macros.svh"
module irrx_front (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic        ir_level,
	input  logic [15:0] bit_period,
	output logic        code_push,
	output logic [7:0]  code
);

	localparam int BW = irrx_pkg::BIT_INDEX_W;

	irrx_pkg::rx_phase_t state_q, state_d;
	logic [15:0]   tick_q, tick_d;
	logic [BW-1:0] bit_idx_q, bit_idx_d;
	logic [7:0]    shift_q, shift_d;
	logic [15:0]   period_eff;
	logic [15:0]   tick_inc;

	assign period_eff = (bit_period < irrx_pkg::BIT_PERIOD_MIN) ?
		irrx_pkg::BIT_PERIOD_MIN : bit_period;
	assign tick_inc = tick_q + 16'd1;
	assign code     = shift_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= irrx_pkg::PH_HUNT;
			tick_q    <= '0;
			bit_idx_q <= '0;
			shift_q   <= '0;
		end else begin
			state_q   <= state_d;
			tick_q    <= tick_d;
			bit_idx_q <= bit_idx_d;
			shift_q   <= shift_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		tick_d    = tick_q;
		bit_idx_d = bit_idx_q;
		shift_d   = shift_q;
		code_push = 1'b0;
		if (accept) begin
			case (state_q)
				irrx_pkg::PH_CONFIRM: begin
					tick_d = tick_inc;
					// The start bit is checked half a bit period after the falling edge.
					if (tick_inc >= (period_eff >> 1)) begin
						tick_d = '0;
						if (!ir_level) begin
							state_d   = irrx_pkg::PH_DATA;
							bit_idx_d = '0;
							shift_d   = '0;
						end else begin
							state_d = irrx_pkg::PH_HUNT;
						end
					end
				end
				irrx_pkg::PH_DATA: begin
					tick_d = tick_inc;
					if (tick_inc >= period_eff) begin
						tick_d = '0;
						if (bit_idx_q < BW'(irrx_pkg::DATA_BITS)) begin
							// LSB first, and a low line level is a one.
							shift_d   = {~ir_level, shift_q[7:1]};
							bit_idx_d = bit_idx_q + 1'b1;
						end else if (bit_idx_q < BW'(irrx_pkg::LAST_BIT_INDEX)) begin
							bit_idx_d = bit_idx_q + 1'b1;
						end else begin
							state_d   = irrx_pkg::PH_HUNT;
							bit_idx_d = '0;
							code_push = 1'b1;
						end
					end
				end
				default: begin
					if (!ir_level) begin
						state_d = irrx_pkg::PH_CONFIRM;
						tick_d  = '0;
					end
				end
			endcase
		end
	end

	`IRRX_ASSERT_NOW(a_bit_idx_range, clk, arst_n, state_q == irrx_pkg::PH_DATA, bit_idx_q <= BW'(irrx_pkg::LAST_BIT_INDEX))
	`IRRX_ASSERT_NOW(a_push_from_data, clk, arst_n, code_push, state_q == irrx_pkg::PH_DATA && bit_idx_q == BW'(irrx_pkg::LAST_BIT_INDEX))
	`IRRX_ASSERT_NEXT(a_start_seen, clk, arst_n, accept && state_q == irrx_pkg::PH_HUNT && !ir_level, state_q == irrx_pkg::PH_CONFIRM && tick_q == '0)

endmodule

// ===== sv/irrx_exec.sv =====
// Command executor: applies each received byte to the volume and channel.
`timescale 1ns / 1ps
`include "ir_remote_command_receiver_top_macros.svh"
module irrx_exec (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        volume_max,
	input  logic [7:0]        channel_max,
	input  logic              cmd_empty,
	input  logic [7:0]        cmd_code,
	output logic              cmd_pop,
	input  logic              res_full,
	output logic              res_push,
	output irrx_pkg::result_t res
);

	logic [7:0] volume_q, volume_d;
	logic [7:0] channel_q, channel_d;
	logic [1:0] ind;
	logic [7:0] cmax;
	logic [8:0] vol_inc;
	logic [8:0] ch_inc;
	logic [7:0] vol_dec;
	logic [7:0] ch_dec;

	assign cmd_pop  = !cmd_empty && !res_full;
	assign res_push = cmd_pop;

	// A channel limit of zero behaves as one.
	assign cmax    = (channel_max == 8'd0) ? irrx_pkg::CHANNEL_MIN : channel_max;
	assign vol_inc = {1'b0, volume_q} + 9'd1;
	assign ch_inc  = {1'b0, channel_q} + 9'd1;
	assign vol_dec = volume_q - 8'd1;
	assign ch_dec  = channel_q - 8'd1;

	always_comb begin
		volume_d  = volume_q;
		channel_d = channel_q;
		ind       = irrx_pkg::IND_DOUBLE;
		case (cmd_code)
			irrx_pkg::CMD_VOL_UP: begin
				if (vol_inc > {1'b0, volume_max}) begin
					volume_d = volume_max;
				end else begin
					volume_d = vol_inc[7:0];
					ind      = irrx_pkg::IND_DONE;
				end
			end
			irrx_pkg::CMD_VOL_DOWN: begin
				if (volume_q == irrx_pkg::VOLUME_RESET) begin
					volume_d = irrx_pkg::VOLUME_RESET;
				end else if (vol_dec > volume_max) begin
					volume_d = volume_max;
				end else begin
					volume_d = vol_dec;
					ind      = irrx_pkg::IND_DONE;
				end
			end
			irrx_pkg::CMD_MUTE: begin
				ind = irrx_pkg::IND_SILENT;
			end
			irrx_pkg::CMD_CH_UP: begin
				if (ch_inc > {1'b0, cmax}) begin
					channel_d = cmax;
				end else begin
					channel_d = ch_inc[7:0];
					ind       = irrx_pkg::IND_DONE;
				end
			end
			irrx_pkg::CMD_CH_DOWN: begin
				if (channel_q <= irrx_pkg::CHANNEL_MIN) begin
					channel_d = irrx_pkg::CHANNEL_MIN;
				end else if (ch_dec > cmax) begin
					channel_d = cmax;
				end else begin
					channel_d = ch_dec;
					ind       = irrx_pkg::IND_DONE;
				end
			end
			irrx_pkg::CMD_CH_RESET: begin
				channel_d = irrx_pkg::CHANNEL_MIN;
				ind       = irrx_pkg::IND_DONE;
			end
			default: begin
				ind = irrx_pkg::IND_DOUBLE;
			end
		endcase
	end

	assign res.command_code   = cmd_code;
	assign res.volume_level   = volume_d;
	assign res.channel_number = channel_d;
	assign res.indication     = ind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume_q  <= irrx_pkg::VOLUME_RESET;
			channel_q <= irrx_pkg::CHANNEL_MIN;
		end else if (cmd_pop) begin
			volume_q  <= volume_d;
			channel_q <= channel_d;
		end
	end

	`IRRX_ASSERT_NOW(a_channel_nonzero, clk, arst_n, 1'b1, channel_q != 8'd0)
	`IRRX_ASSERT_NEXT(a_volume_kept, clk, arst_n, cmd_pop && cmd_code != irrx_pkg::CMD_VOL_UP && cmd_code != irrx_pkg::CMD_VOL_DOWN, $stable(volume_q))
	`IRRX_ASSERT_NEXT(a_channel_reset, clk, arst_n, cmd_pop && cmd_code == irrx_pkg::CMD_CH_RESET, channel_q == irrx_pkg::CHANNEL_MIN)

endmodule

// ===== sv/ir_remote_command_receiver_top.sv =====
// Top level of the IR remote command receiver: configuration registers, sampler, queues and executor.
//
// One IR line sample is taken per clock whenever push is high and full is low; full rises
// only when the command queue between the line sampler and the executor holds CMD_DEPTH
// received bytes that the result side has not yet drained. A frame is a low start bit
// checked half a bit period after its falling edge, eight data bits one bit period apart
// (LSB first, low means one) and three unchecked stop periods. The accepted sample that
// closes the last stop period writes the received byte into the command queue; the
// executor then pops it and writes the result word into the result queue whenever that
// queue has room, after which the word appears on the result ports and can be popped.
// bit_period (values below 2 act as 2), volume_max and channel_max are written through
// the APB port at byte addresses 0, 4 and 8; reads return the stored values.
`timescale 1ns / 1ps
module ir_remote_command_receiver_top #(
	parameter int CMD_DEPTH = irrx_pkg::CMD_DEPTH,
	parameter int OUT_DEPTH = irrx_pkg::OUT_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [irrx_pkg::PADDR_W-1:0]  paddr,
	input  logic [irrx_pkg::PDATA_W-1:0]  pwdata,
	output logic [irrx_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	input  logic                          push,
	output logic                          full,
	input  logic                          ir_level,
	output logic                          empty,
	input  logic                          pop,
	output logic [7:0]                    command_code,
	output logic [7:0]                    volume_level,
	output logic [7:0]                    channel_number,
	output logic [1:0]                    indication
);

	logic [15:0]       bit_period_q;
	logic [7:0]        volume_max_q;
	logic [7:0]        channel_max_q;
	logic              cfg_write;
	logic [1:0]        reg_idx;
	logic              accept;
	logic              code_push;
	logic [7:0]        code;
	logic              cmd_empty;
	logic              cmd_pop;
	logic [7:0]        cmd_code;
	logic              res_full;
	logic              res_push;
	irrx_pkg::result_t res_in;
	irrx_pkg::result_t res_out;

	assign pready    = 1'b1;
	assign reg_idx   = paddr[3:2];
	assign cfg_write = psel && penable && pwrite && pready;
	assign accept    = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_period_q  <= irrx_pkg::BIT_PERIOD_RESET;
			volume_max_q  <= irrx_pkg::VOLUME_MAX_RESET;
			channel_max_q <= irrx_pkg::CHANNEL_MAX_RESET;
		end else if (cfg_write) begin
			case (reg_idx)
				irrx_pkg::REG_BIT_PERIOD:  bit_period_q  <= pwdata[15:0];
				irrx_pkg::REG_VOLUME_MAX:  volume_max_q  <= pwdata[7:0];
				irrx_pkg::REG_CHANNEL_MAX: channel_max_q <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			irrx_pkg::REG_BIT_PERIOD:  prdata = {16'd0, bit_period_q};
			irrx_pkg::REG_VOLUME_MAX:  prdata = {24'd0, volume_max_q};
			irrx_pkg::REG_CHANNEL_MAX: prdata = {24'd0, channel_max_q};
			default:                   prdata = '0;
		endcase
	end

	irrx_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.ir_level   (ir_level),
		.bit_period (bit_period_q),
		.code_push  (code_push),
		.code       (code)
	);

	irrx_fifo #(
		.WIDTH (8),
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (code_push),
		.wdata  (code),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (cmd_code),
		.empty  (cmd_empty)
	);

	irrx_exec u_exec (
		.clk         (clk),
		.arst_n      (arst_n),
		.volume_max  (volume_max_q),
		.channel_max (channel_max_q),
		.cmd_empty   (cmd_empty),
		.cmd_code    (cmd_code),
		.cmd_pop     (cmd_pop),
		.res_full    (res_full),
		.res_push    (res_push),
		.res         (res_in)
	);

	irrx_fifo #(
		.WIDTH ($bits(irrx_pkg::result_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty)
	);

	assign command_code   = res_out.command_code;
	assign volume_level   = res_out.volume_level;
	assign channel_number = res_out.channel_number;
	assign indication     = res_out.indication;

endmodule
